// ----- src/pac_pkg.sv -----
// Package: types, constants and codes shared by the polygon area/centroid block.
package pac_pkg;

  localparam int unsigned MaxVerticesDefault = 4096;
  localparam int unsigned FractionBitsDefault = 8;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 13;
  localparam int unsigned AreaW = 46;
  localparam int unsigned MomentW = 63;
  localparam int unsigned CenW = 24;
  // Magnitude of a moment plus fraction shift, plus two guard bits.
  localparam int unsigned DivW = 64 + 12 + 2;
  localparam int unsigned ProdW = 2 * CoordW + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     last_vertex;
  } pac_in_t;

  typedef struct packed {
    logic signed [AreaW-1:0] twice_signed_area;
    logic signed [CenW-1:0]  centroid_x;
    logic signed [CenW-1:0]  centroid_y;
    logic [CountW-1:0]       vertex_total;
    logic                    degenerate;
    logic                    overflow;
  } pac_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CROSS,
    ST_MOMENT,
    ST_CLOSE_CROSS,
    ST_CLOSE_MOMENT,
    ST_DIV_X_START,
    ST_DIV_X,
    ST_DIV_Y_START,
    ST_DIV_Y,
    ST_OUTPUT
  } pac_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_vertex;   // capture the input vertex
    logic edge_cross;    // compute cross product of the open edge
    logic edge_moment;   // accumulate the open edge
    logic close_cross;   // cross product of the closing edge
    logic close_moment;  // accumulate the closing edge
    logic div_start;     // load the divider
    logic div_sel_y;     // divider works on the y moment
    logic div_store;     // latch the finished quotient
    logic out_load;      // build the result register
    logic clear;         // return accumulators to reset
  } pac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic accept_edge;   // vertex is accumulated (count in 1..max-1)
    logic area_zero;
    logic enough;        // count >= 3
    logic div_done;
  } pac_status_t;

endpackage

// ----- src/polygon_area_centroid.sv -----
// Top level: polygon shoelace area and centroid, streamed one vertex per transfer.
//
// Input channel in_valid/in_stall/in_data carries one vertex per transfer;
// last_vertex closes the polygon. Output channel out_valid/out_stall/out_data
// carries one result per polygon.
// A vertex is captured, then its cross product is multiplied and registered, then
// the moment products are formed and accumulated; the registered cross product
// feeds the 33x17 moment multipliers, and input stays stalled meanwhile.
// At the last vertex the closing edge gets its own cross product and moment
// steps, then the shared serial divider runs twice (x then y), one quotient bit
// per cycle. Polygons with under three vertices or zero area skip the divide.
// The result sits in an output register; input is stalled from the last
// vertex until the result register is free again, so a stalled receiver
// holds off the next polygon only while a previous result is still untaken.
// Reset (rst, synchronous) clears all accumulators and drops out_valid.
// Vertices beyond MAX_VERTICES are dropped and flagged as overflow.
module polygon_area_centroid #(
  parameter int unsigned MAX_VERTICES = pac_pkg::MaxVerticesDefault,
  parameter int unsigned FRACTION_BITS = pac_pkg::FractionBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pac_pkg::pac_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pac_pkg::pac_out_t out_data
);
  import pac_pkg::*;

  pac_cmd_t cmd;
  pac_status_t status;
  logic out_busy;

  assign out_busy = out_valid && out_stall;

  pac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(in_data.last_vertex),
    .in_stall(in_stall), .out_busy(out_busy), .status(status), .cmd(cmd)
  );

  pac_datapath #(.MAX_VERTICES(MAX_VERTICES), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cmd(cmd), .status(status),
    .result(out_data)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // A new result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> !out_busy)
    else $error("result overwritten while stalled");
  // No vertex is taken while a divide is being loaded
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> in_stall)
    else $error("input accepted during divide");
  // A degenerate result carries zero centroid
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |->
      (out_data.centroid_x == '0 && out_data.centroid_y == '0))
    else $error("degenerate result with nonzero centroid");

endmodule

// ----- src/pac_ctrl.sv -----
// Controller: sequences edge accumulation, polygon close, the two divides and output.
module pac_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_stall,
  input  logic                out_busy,
  input  pac_pkg::pac_status_t status,
  output pac_pkg::pac_cmd_t    cmd
);
  import pac_pkg::*;

  pac_state_t state, state_next;
  logic last_reg, last_reg_next;
  logic take;

  // Input is only open in idle, so a transfer is valid while idle
  assign take = in_valid && (state == ST_IDLE);

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      last_reg <= 1'b0;
    end else begin
      state <= state_next;
      last_reg <= last_reg_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    last_reg_next = last_reg;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          last_reg_next = in_last;
          state_next = ST_CROSS;
        end
      end
      ST_CROSS: state_next = ST_MOMENT;
      ST_MOMENT: begin
        if (!last_reg) state_next = ST_IDLE;
        else if (status.enough) state_next = ST_CLOSE_CROSS;
        else state_next = ST_OUTPUT;
      end
      ST_CLOSE_CROSS: state_next = ST_CLOSE_MOMENT;
      ST_CLOSE_MOMENT: state_next = ST_DIV_X_START;
      ST_DIV_X_START: state_next = status.area_zero ? ST_OUTPUT : ST_DIV_X;
      ST_DIV_X: if (status.div_done) state_next = ST_DIV_Y_START;
      ST_DIV_Y_START: state_next = ST_DIV_Y;
      ST_DIV_Y: if (status.div_done) state_next = ST_OUTPUT;
      ST_OUTPUT: if (!out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load_vertex = take;
      end
      ST_CROSS: cmd.edge_cross = 1'b1;
      ST_MOMENT: cmd.edge_moment = status.accept_edge;
      ST_CLOSE_CROSS: cmd.close_cross = 1'b1;
      ST_CLOSE_MOMENT: cmd.close_moment = 1'b1;
      ST_DIV_X_START: cmd.div_start = !status.area_zero;
      ST_DIV_X: cmd.div_store = status.div_done;
      ST_DIV_Y_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
      end
      ST_DIV_Y: begin
        cmd.div_sel_y = 1'b1;
        cmd.div_store = status.div_done;
      end
      ST_OUTPUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- src/pac_div.sv -----
// Restoring divider: one quotient bit per cycle, unsigned.
module pac_div #(
  parameter int unsigned W = pac_pkg::DivW
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  import pac_pkg::*;

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0] rem, quo, den;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [W:0] trial;

  assign trial = {rem, quo[W-1]} - {1'b0, den};
  assign done = busy && (cnt == '0);
  assign quotient = quo;

  // Shift-subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CntW'(W);
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy && cnt != '0) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/pac_datapath.sv -----
// Datapath: vertex registers, shoelace accumulators, divider and result register.
module pac_datapath #(
  parameter int unsigned MAX_VERTICES = pac_pkg::MaxVerticesDefault,
  parameter int unsigned FRACTION_BITS = pac_pkg::FractionBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pac_pkg::pac_in_t     in_data,
  input  pac_pkg::pac_cmd_t    cmd,
  output pac_pkg::pac_status_t status,
  output pac_pkg::pac_out_t    result
);
  import pac_pkg::*;

  localparam int unsigned MomW = 64;

  logic signed [CoordW-1:0] first_x, first_y, prev_x, prev_y, cur_x, cur_y;
  logic [CountW-1:0] count;
  logic signed [AreaW-1:0] area_acc;
  logic signed [MomentW-1:0] moment_x_acc, moment_y_acc;
  logic overflow_seen, sat_seen, edge_ok;
  logic signed [ProdW-1:0] cross_prod;
  logic signed [CenW-1:0] cen_x;

  // Edge operands: open edge prev->cur, closing edge prev->first
  logic signed [CoordW-1:0] qx, qy;
  assign qx = cmd.close_cross ? first_x : cur_x;
  assign qy = cmd.close_cross ? first_y : cur_y;

  logic signed [ProdW-1:0] p1, p2;
  assign p1 = ProdW'(prev_x) * ProdW'(qy);
  assign p2 = ProdW'(prev_y) * ProdW'(qx);

  // Moment operands
  logic signed [CoordW:0] sx, sy, mx_q, my_q;
  assign mx_q = cmd.close_moment ? CoordW'(0) + first_x : CoordW'(0) + cur_x;
  assign my_q = cmd.close_moment ? CoordW'(0) + first_y : CoordW'(0) + cur_y;
  assign sx = (CoordW+1)'(prev_x) + mx_q;
  assign sy = (CoordW+1)'(prev_y) + my_q;

  // Full-width moment products, then sign-extended to the accumulator
  logic signed [ProdW+CoordW:0] mx_prod, my_prod;
  assign mx_prod = cross_prod * sx;
  assign my_prod = cross_prod * sy;

  logic signed [MomentW-1:0] mx_add, my_add;
  assign mx_add = MomentW'(mx_prod);
  assign my_add = MomentW'(my_prod);

  // Vertex capture, cross product register, accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      first_x <= '0; first_y <= '0; prev_x <= '0; prev_y <= '0;
      count <= '0; area_acc <= '0; moment_x_acc <= '0; moment_y_acc <= '0;
      overflow_seen <= 1'b0; edge_ok <= 1'b0;
    end else begin
      if (cmd.load_vertex) begin
        cur_x <= in_data.vertex_x;
        cur_y <= in_data.vertex_y;
        edge_ok <= 1'b0;
        if (count >= CountW'(MAX_VERTICES)) begin
          overflow_seen <= 1'b1;
        end else if (count == '0) begin
          first_x <= in_data.vertex_x; first_y <= in_data.vertex_y;
          prev_x <= in_data.vertex_x;  prev_y <= in_data.vertex_y;
          count <= CountW'(1);
        end else begin
          count <= count + 1'b1;
          edge_ok <= 1'b1;
        end
      end
      if (cmd.edge_cross || cmd.close_cross) cross_prod <= p1 - p2;
      if (cmd.edge_moment || cmd.close_moment) begin
        area_acc <= area_acc + AreaW'(cross_prod);
        moment_x_acc <= moment_x_acc + mx_add;
        moment_y_acc <= moment_y_acc + my_add;
      end
      if (cmd.edge_moment) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
    end
  end

  // Divider operands: |moment| << F over |3 * area|
  logic signed [MomW-1:0] den3;
  logic [MomW-1:0] num_mag, den_mag;
  logic signed [MomentW-1:0] num_s;
  logic neg;
  assign num_s = cmd.div_sel_y ? moment_y_acc : moment_x_acc;
  assign den3 = MomW'(area_acc) + (MomW'(area_acc) <<< 1);
  assign num_mag = num_s[MomentW-1] ? MomW'(-MomW'(num_s)) : MomW'(num_s);
  assign den_mag = den3[MomW-1] ? -den3 : den3;
  assign neg = num_s[MomentW-1] != den3[MomW-1];

  logic div_done;
  logic [DivW-1:0] quo;
  pac_div #(.W(DivW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(DivW'(num_mag) << FRACTION_BITS),
    .divisor(DivW'(den_mag)),
    .done(div_done), .quotient(quo)
  );

  // Saturate the quotient to the signed centroid range
  logic signed [CenW-1:0] cen_val;
  logic cen_sat;
  always_comb begin
    cen_sat = 1'b0;
    if (neg) begin
      if (quo > DivW'(24'h800000)) begin
        cen_sat = 1'b1;
        cen_val = CenW'(24'h800000);
      end else begin
        cen_val = -CenW'(quo);
      end
    end else begin
      if (quo > DivW'(24'h7FFFFF)) begin
        cen_sat = 1'b1;
        cen_val = CenW'(24'h7FFFFF);
      end else begin
        cen_val = CenW'(quo);
      end
    end
  end

  logic signed [CenW-1:0] cen_y;
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sat_seen <= 1'b0;
      cen_x <= '0;
      cen_y <= '0;
    end else if (cmd.div_store) begin
      if (cmd.div_sel_y) cen_y <= cen_val;
      else cen_x <= cen_val;
      sat_seen <= sat_seen | cen_sat;
    end
  end

  // Result register
  logic enough, area_zero;
  assign enough = count >= CountW'(3);
  assign area_zero = area_acc == '0;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.twice_signed_area <= enough ? area_acc : '0;
      result.centroid_x <= cen_x;
      result.centroid_y <= cen_y;
      result.vertex_total <= count;
      result.degenerate <= !enough || area_zero;
      result.overflow <= overflow_seen || sat_seen;
    end
  end

  assign status.accept_edge = edge_ok;
  assign status.area_zero = area_zero;
  assign status.enough = enough;
  assign status.div_done = div_done;

endmodule

// ----- verif/polygon_area_centroid_tb.sv -----
// Testbench for polygon_area_centroid: directed and random polygons checked against a shoelace predictor.
module polygon_area_centroid_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pac_pkg::*;

  localparam int unsigned MaxVerts = MaxVerticesDefault;
  localparam int unsigned FracBits = FractionBitsDefault;
  localparam longint CycleLimit = 3000000;
  localparam int RandomItems = 500;

  // Expected polygon results and the running shoelace sums behind them
  class area_scoreboard;
    pac_out_t    results_q[$];
    int          errors;
    longint      first_x, first_y, prev_x, prev_y;
    longint      area_sum, mom_x_sum, mom_y_sum;
    int unsigned vert_count;
    bit          dropped;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      area_sum = 0; mom_x_sum = 0; mom_y_sum = 0;
      vert_count = 0;
      dropped = 0;
    endfunction

    function void add_edge(longint px, longint py, longint qx, longint qy);
      longint cross_prod;
      cross_prod = px * qy - py * qx;
      area_sum += cross_prod;
      mom_x_sum += cross_prod * (px + qx);
      mom_y_sum += cross_prod * (py + qy);
    endfunction

    // moment * 2^FracBits / den3, truncated toward zero, saturated to 24 bits
    function logic [CenW-1:0] centroid(longint num, longint den3, inout bit sat);
      bit [63:0] n, d, q, r, lim;
      bit        neg;
      n = (num < 0) ? -num : num;
      d = (den3 < 0) ? -den3 : den3;
      neg = (num < 0) != (den3 < 0);
      q = n / d;
      r = n % d;
      lim = neg ? 64'd8388608 : 64'd8388607;
      if (q <= lim) begin
        for (int i = 0; i < FracBits; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= d) begin
            r -= d;
            q[0] = 1'b1;
          end
        end
      end
      if (q > lim) begin
        sat = 1;
        q = lim;
      end
      if (neg) q = -q;
      return q[CenW-1:0];
    endfunction

    function int pending();
      return results_q.size();
    endfunction

    function void note_vertex(pac_in_t v);
      longint   x, y;
      pac_out_t res;
      bit       sat;
      x = longint'(signed'(v.vertex_x));
      y = longint'(signed'(v.vertex_y));
      sat = 0;
      if (vert_count >= MaxVerts) begin
        dropped = 1;
      end else if (vert_count == 0) begin
        first_x = x; prev_x = x;
        first_y = y; prev_y = y;
        vert_count = 1;
      end else begin
        add_edge(prev_x, prev_y, x, y);
        prev_x = x;
        prev_y = y;
        vert_count++;
      end
      if (!v.last_vertex) return;
      res = '0;
      res.degenerate = 1'b1;
      if (vert_count >= 3) begin
        add_edge(prev_x, prev_y, first_x, first_y);
        res.twice_signed_area = area_sum[AreaW-1:0];
        if (area_sum != 0) begin
          res.degenerate = 1'b0;
          res.centroid_x = centroid(mom_x_sum, 3 * area_sum, sat);
          res.centroid_y = centroid(mom_y_sum, 3 * area_sum, sat);
        end
      end
      res.vertex_total = vert_count[CountW-1:0];
      res.overflow = dropped | sat;
      results_q.insert(results_q.size(), res);
      clear();
    endfunction

    function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v,
                 act_v);
      end
    endfunction

    function void check_result(pac_out_t got);
      pac_out_t exp_r;
      if (results_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        return;
      end
      exp_r = results_q.pop_front();
      field_check("twice_signed_area", exp_r.twice_signed_area, got.twice_signed_area);
      field_check("centroid_x", exp_r.centroid_x, got.centroid_x);
      field_check("centroid_y", exp_r.centroid_y, got.centroid_y);
      field_check("vertex_total", exp_r.vertex_total, got.vertex_total);
      field_check("degenerate", exp_r.degenerate, got.degenerate);
      field_check("overflow", exp_r.overflow, got.overflow);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  pac_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pac_out_t out_data;

  area_scoreboard sb = new();
  bit     quiet = 0;
  bit     hold_req = 0;
  longint cycles = 0;

  polygon_area_centroid DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: random stall bursts, plus long holds on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One vertex transfer, then maybe a gap
  task automatic send(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y, bit last);
    pac_in_t v;
    v.vertex_x = x;
    v.vertex_y = y;
    v.last_vertex = last;
    in_data <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_vertex(v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Polygon with random content; mode picks the coordinate style
  task automatic send_polygon(int unsigned nverts, int mode);
    logic signed [CoordW-1:0] x, y;
    logic signed [CoordW-1:0] bx, by;
    bx = CoordW'($urandom);
    by = CoordW'($urandom);
    for (int unsigned i = 0; i < nverts; i++) begin
      case (mode)
        0: begin x = CoordW'($urandom); y = CoordW'($urandom); end
        1: begin
          x = CoordW'($urandom_range(0, 200)) - 16'sd100;
          y = CoordW'($urandom_range(0, 200)) - 16'sd100;
        end
        2: begin x = bx; y = by; end
        3: begin x = bx + CoordW'(i); y = by + CoordW'(2 * i); end
        default: begin
          x = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
          y = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        end
      endcase
      send(x, y, i == nverts - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int sent;
    int unsigned n;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: lone vertex, two vertices, square both ways, extremes, collinear, bowtie
    send(16'sh8000, 16'sh7fff, 1);
    send(16'sh0001, 16'sh0002, 0);
    send(16'sh0003, 16'sh0004, 1);
    send(0, 0, 0); send(10, 0, 0); send(10, 10, 0); send(0, 10, 1);
    send(0, 0, 0); send(0, 10, 0); send(10, 10, 0); send(10, 0, 1);
    send(16'sh8000, 16'sh8000, 0); send(16'sh7fff, 16'sh8000, 0);
    send(16'sh7fff, 16'sh7fff, 0); send(16'sh8000, 16'sh7fff, 1);
    send(5, 5, 0); send(6, 6, 0); send(7, 7, 1);
    send(16'sh8000, 16'sh8000, 0); send(16'sh7fff, 16'sh7fff, 0);
    send(16'sh7fff, 16'sh8000, 0); send(16'sh8001, 16'sh7fff, 1);
    drain();

    // Random polygons; a long receiver hold early on, a full drain midway
    sent = 0;
    while (sent < RandomItems) begin
      if (sent > 40 && sent < 60) hold_req = 1;
      if (sent > 250 && sent < 262) drain();
      if (sent > RandomItems * 85 / 100) quiet = 1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      send_polygon(n, ($urandom_range(0, 9) < 5) ? 0 : $urandom_range(1, 4));
      sent += n;
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/pac_pkg.sv
src/pac_ctrl.sv
src/pac_div.sv
src/pac_datapath.sv
src/polygon_area_centroid.sv
verif/polygon_area_centroid_tb.sv
